### hdl/met_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_pkg: shared types and constants for the escape-time block
// Fixed-point formats, register codes and the multiplier request/response.
// ----------------------------------------------------------------------------
package met_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COUNT_BITS = 16;
    localparam int PER_W      = 16;
    localparam int CRD_W      = 32;
    localparam int VAL_W      = 48;
    localparam int MAG_W      = 36;
    localparam int HALF_W     = MAG_W / 2;
    localparam int PP_W       = MAG_W + HALF_W;
    localparam int ACC_W      = 2 * MAG_W;
    localparam int MAGSQ_W    = 34;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 34;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 56;

    localparam logic signed [VAL_W-1:0] QUARTER   = VAL_W'(64'd1 << (FRAC_BITS - 2));
    localparam logic signed [VAL_W-1:0] SIXTEENTH = VAL_W'(64'd1 << (FRAC_BITS - 4));
    localparam logic signed [VAL_W-1:0] ONE       = VAL_W'(64'd1 << FRAC_BITS);

    localparam logic [MAGSQ_W-1:0]    MAGSQ_MAX    = {MAGSQ_W{1'b1}};
    localparam logic [COUNT_BITS-1:0] MAX_ITER_RST = COUNT_BITS'(256);
    localparam logic [MAGSQ_W-1:0]    BAILOUT_RST  = MAGSQ_W'(64'd1 << (FRAC_BITS + 2));
    localparam logic [PER_W-1:0]      PERIOD_RST   = PER_W'(20);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MAX_ITER = 2'd0,
        CFG_BAILOUT  = 2'd1,
        CFG_PERIOD   = 2'd2
    } cfg_addr_t;

    typedef struct packed {
        logic                    start;
        logic                    half;
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] result;
    } mul_rsp_t;

endpackage
`default_nettype wire

### hdl/met_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_mul: shared fixed-point multiplier
// Signed product truncated toward zero, built from two passes of a
// 36x18 unsigned multiplier on the operand magnitudes.
// ----------------------------------------------------------------------------
module met_mul (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire met_pkg::mul_req_t req,
    output met_pkg::mul_rsp_t      rsp
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_ABS,
        M_LO,
        M_HI,
        M_ACC,
        M_FIN
    } mstate_t;

    mstate_t                           state_reg;
    logic signed [met_pkg::VAL_W-1:0]  a_raw_reg;
    logic signed [met_pkg::VAL_W-1:0]  b_raw_reg;
    logic [met_pkg::MAG_W-1:0]         a_reg;
    logic [met_pkg::MAG_W-1:0]         b_reg;
    logic                              neg_reg;
    logic                              half_reg;
    logic [met_pkg::PP_W-1:0]          pp_reg;
    logic [met_pkg::ACC_W-1:0]         acc_reg;
    logic signed [met_pkg::VAL_W-1:0]  res_reg;
    logic                              done_reg;

    logic [met_pkg::VAL_W-1:0] a_abs;
    logic [met_pkg::VAL_W-1:0] b_abs;
    logic [met_pkg::ACC_W-1:0] shifted;
    logic [met_pkg::VAL_W-1:0] sh_val;

    assign a_abs   = a_raw_reg[met_pkg::VAL_W-1] ? $unsigned(-a_raw_reg) : $unsigned(a_raw_reg);
    assign b_abs   = b_raw_reg[met_pkg::VAL_W-1] ? $unsigned(-b_raw_reg) : $unsigned(b_raw_reg);
    assign shifted = half_reg ? (acc_reg >> (met_pkg::FRAC_BITS - 1))
                              : (acc_reg >> met_pkg::FRAC_BITS);
    assign sh_val  = shifted[met_pkg::VAL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE: begin
                    if (req.start) begin
                        a_raw_reg <= req.a;
                        b_raw_reg <= req.b;
                        half_reg  <= req.half;
                        state_reg <= M_ABS;
                    end
                end
                M_ABS: begin
                    a_reg     <= a_abs[met_pkg::MAG_W-1:0];
                    b_reg     <= b_abs[met_pkg::MAG_W-1:0];
                    neg_reg   <= a_raw_reg[met_pkg::VAL_W-1] ^ b_raw_reg[met_pkg::VAL_W-1];
                    state_reg <= M_LO;
                end
                M_LO: begin
                    pp_reg    <= a_reg * b_reg[met_pkg::HALF_W-1:0];
                    state_reg <= M_HI;
                end
                M_HI: begin
                    pp_reg    <= a_reg * b_reg[met_pkg::MAG_W-1:met_pkg::HALF_W];
                    acc_reg   <= met_pkg::ACC_W'(pp_reg);
                    state_reg <= M_ACC;
                end
                M_ACC: begin
                    acc_reg   <= acc_reg + (met_pkg::ACC_W'(pp_reg) << met_pkg::HALF_W);
                    state_reg <= M_FIN;
                end
                M_FIN: begin
                    res_reg   <= neg_reg ? -sh_val : sh_val;
                    done_reg  <= 1'b1;
                    state_reg <= M_IDLE;
                end
                default: begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = done_reg;
    assign rsp.result = res_reg;

endmodule
`default_nettype wire

### hdl/mandelbrot_escape_time_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top: escape-time iteration for one point per item
// Tests the main cardioid and period-2 bulb, then iterates z = z*z + c with
// bailout, iteration limit and periodicity snapshot checks.
// ----------------------------------------------------------------------------
// One point is worked at a time; s_tready is high only while the block is
// idle. Every product goes through one shared 36x18 multiplier, and one
// iteration takes three products plus a loop check. A point in the main
// cardioid returns after the cardioid test, one in the period-2 bulb after
// the bulb test, and any other point after the iterations it runs. The
// result sits in an output register, so the next point can be accepted
// while the previous result waits on m_tready.
module mandelbrot_escape_time_top (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [met_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [met_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [met_pkg::S_TDATA_W-1:0]    s_tdata,   // c_real, c_imag
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [met_pkg::M_TDATA_W-1:0]         m_tdata,   // iteration_count, final_magnitude_sq
    output logic                                  m_tuser    // inside_set
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_Y2,
        S_X2,
        S_TT,
        S_QS,
        S_CARD,
        S_BULB,
        S_LOOP,
        S_XY,
        S_XX,
        S_YY,
        S_OUT
    } state_t;

    logic [met_pkg::COUNT_BITS-1:0] max_iter_reg;
    logic [met_pkg::MAGSQ_W-1:0]    bailout_reg;
    logic [met_pkg::PER_W-1:0]      period_reg;

    state_t                           state_reg;
    logic signed [met_pkg::CRD_W-1:0] cx_reg;
    logic signed [met_pkg::CRD_W-1:0] cy_reg;
    logic signed [met_pkg::VAL_W-1:0] x_reg;
    logic signed [met_pkg::VAL_W-1:0] y_reg;
    logic signed [met_pkg::VAL_W-1:0] px_reg;
    logic signed [met_pkg::VAL_W-1:0] py_reg;
    logic signed [met_pkg::VAL_W-1:0] x2_reg;
    logic signed [met_pkg::VAL_W-1:0] y2_reg;
    logic signed [met_pkg::VAL_W-1:0] t_reg;
    logic signed [met_pkg::VAL_W-1:0] u_reg;
    logic signed [met_pkg::VAL_W-1:0] q_reg;
    logic [met_pkg::COUNT_BITS-1:0]   count_reg;
    logic [met_pkg::PER_W-1:0]        pc_reg;
    logic                             inside_reg;
    met_pkg::mul_req_t                req_reg;

    logic                             m_tvalid_reg;
    logic [met_pkg::COUNT_BITS-1:0]   out_count_reg;
    logic                             out_inside_reg;
    logic [met_pkg::MAGSQ_W-1:0]      out_mag_reg;

    met_pkg::mul_rsp_t                mul_rsp;
    logic signed [met_pkg::VAL_W-1:0] in_cx;
    logic signed [met_pkg::VAL_W-1:0] in_cy;
    logic signed [met_pkg::VAL_W-1:0] x_new;
    logic signed [met_pkg::VAL_W-1:0] mag_sum;
    logic [met_pkg::MAGSQ_W-1:0]      mag_sat;
    logic                             keep_going;
    logic                             fin_inside;
    logic [met_pkg::PER_W:0]          pc_inc;
    logic                             pc_hit;
    logic                             card_hit;
    logic                             bulb_hit;

    met_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req_reg),
        .rsp     (mul_rsp)
    );

    assign in_cx      = met_pkg::VAL_W'($signed(s_tdata[met_pkg::CRD_W-1:0]));
    assign in_cy      = met_pkg::VAL_W'($signed(s_tdata[2*met_pkg::CRD_W-1:met_pkg::CRD_W]));
    assign x_new      = x2_reg - y2_reg + met_pkg::VAL_W'(cx_reg);
    assign mag_sum    = x2_reg + y2_reg;
    assign mag_sat    = ($unsigned(mag_sum) > met_pkg::VAL_W'(met_pkg::MAGSQ_MAX))
                        ? met_pkg::MAGSQ_MAX : mag_sum[met_pkg::MAGSQ_W-1:0];
    assign keep_going = (count_reg < max_iter_reg)
                        && ($unsigned(mag_sum) <= met_pkg::VAL_W'(bailout_reg));
    assign fin_inside = inside_reg || (count_reg >= max_iter_reg);
    assign pc_inc     = {1'b0, pc_reg} + (met_pkg::PER_W + 1)'(1);
    assign pc_hit     = pc_inc >= {1'b0, period_reg};
    assign card_hit   = mul_rsp.result <= (y2_reg >>> 2);
    assign bulb_hit   = (mul_rsp.result + y2_reg) <= met_pkg::SIXTEENTH;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_iter_reg <= met_pkg::MAX_ITER_RST;
            bailout_reg  <= met_pkg::BAILOUT_RST;
            period_reg   <= met_pkg::PERIOD_RST;
        end else if (cfg_wr_en) begin
            case (met_pkg::cfg_addr_t'(cfg_addr))
                met_pkg::CFG_MAX_ITER: max_iter_reg <= cfg_wdata[met_pkg::COUNT_BITS-1:0];
                met_pkg::CFG_BAILOUT:  bailout_reg  <= cfg_wdata[met_pkg::MAGSQ_W-1:0];
                met_pkg::CFG_PERIOD:   period_reg   <= cfg_wdata[met_pkg::PER_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            req_reg.start <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            req_reg.start <= 1'b0;
            if (m_tvalid_reg && m_tready && state_reg != S_OUT) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cx_reg        <= s_tdata[met_pkg::CRD_W-1:0];
                        cy_reg        <= s_tdata[2*met_pkg::CRD_W-1:met_pkg::CRD_W];
                        x_reg         <= in_cx;
                        y_reg         <= in_cy;
                        px_reg        <= in_cx;
                        py_reg        <= in_cy;
                        t_reg         <= in_cx - met_pkg::QUARTER;
                        u_reg         <= in_cx + met_pkg::ONE;
                        count_reg     <= met_pkg::COUNT_BITS'(1);
                        pc_reg        <= met_pkg::PER_W'(1);
                        inside_reg    <= 1'b0;
                        req_reg.start <= 1'b1;
                        req_reg.half  <= 1'b0;
                        req_reg.a     <= in_cy;
                        req_reg.b     <= in_cy;
                        state_reg     <= S_Y2;
                    end
                end
                S_Y2: begin
                    if (mul_rsp.done) begin
                        y2_reg        <= mul_rsp.result;
                        req_reg.start <= 1'b1;
                        req_reg.half  <= 1'b0;
                        req_reg.a     <= met_pkg::VAL_W'(cx_reg);
                        req_reg.b     <= met_pkg::VAL_W'(cx_reg);
                        state_reg     <= S_X2;
                    end
                end
                S_X2: begin
                    if (mul_rsp.done) begin
                        x2_reg        <= mul_rsp.result;
                        req_reg.start <= 1'b1;
                        req_reg.half  <= 1'b0;
                        req_reg.a     <= t_reg;
                        req_reg.b     <= t_reg;
                        state_reg     <= S_TT;
                    end
                end
                S_TT: begin
                    if (mul_rsp.done) begin
                        q_reg     <= mul_rsp.result + y2_reg;
                        state_reg <= S_QS;
                    end
                end
                S_QS: begin
                    req_reg.start <= 1'b1;
                    req_reg.half  <= 1'b0;
                    req_reg.a     <= q_reg;
                    req_reg.b     <= q_reg + t_reg;
                    state_reg     <= S_CARD;
                end
                S_CARD: begin
                    if (mul_rsp.done) begin
                        if (card_hit) begin
                            inside_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end else begin
                            req_reg.start <= 1'b1;
                            req_reg.half  <= 1'b0;
                            req_reg.a     <= u_reg;
                            req_reg.b     <= u_reg;
                            state_reg     <= S_BULB;
                        end
                    end
                end
                S_BULB: begin
                    if (mul_rsp.done) begin
                        if (bulb_hit) begin
                            inside_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end else begin
                            state_reg <= S_LOOP;
                        end
                    end
                end
                S_LOOP: begin
                    if (keep_going) begin
                        req_reg.start <= 1'b1;
                        req_reg.half  <= 1'b1;
                        req_reg.a     <= x_reg;
                        req_reg.b     <= y_reg;
                        x_reg         <= x_new;
                        state_reg     <= S_XY;
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_XY: begin
                    if (mul_rsp.done) begin
                        y_reg         <= mul_rsp.result + met_pkg::VAL_W'(cy_reg);
                        req_reg.start <= 1'b1;
                        req_reg.half  <= 1'b0;
                        req_reg.a     <= x_reg;
                        req_reg.b     <= x_reg;
                        state_reg     <= S_XX;
                    end
                end
                S_XX: begin
                    if (mul_rsp.done) begin
                        x2_reg        <= mul_rsp.result;
                        req_reg.start <= 1'b1;
                        req_reg.half  <= 1'b0;
                        req_reg.a     <= y_reg;
                        req_reg.b     <= y_reg;
                        state_reg     <= S_YY;
                    end
                end
                S_YY: begin
                    if (mul_rsp.done) begin
                        y2_reg    <= mul_rsp.result;
                        count_reg <= count_reg + met_pkg::COUNT_BITS'(1);
                        state_reg <= S_LOOP;
                        if (pc_hit) begin
                            pc_reg <= '0;
                            if (px_reg == x_reg && py_reg == y_reg) begin
                                inside_reg <= 1'b1;
                                state_reg  <= S_OUT;
                            end else begin
                                px_reg <= x_reg;
                                py_reg <= y_reg;
                            end
                        end else begin
                            pc_reg <= pc_inc[met_pkg::PER_W-1:0];
                        end
                    end
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg   <= 1'b1;
                        out_count_reg  <= fin_inside ? max_iter_reg : count_reg;
                        out_inside_reg <= fin_inside;
                        out_mag_reg    <= mag_sat;
                        state_reg      <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = met_pkg::M_TDATA_W'({out_mag_reg, out_count_reg});
    assign m_tuser  = out_inside_reg;

endmodule
`default_nettype wire

### hdl/met_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// met_checker: port-level checks for the escape-time block
// Tracks the limit and bailout registers from the write port and checks
// results and handshakes against them.
// ----------------------------------------------------------------------------
module met_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             cfg_wr_en,
    input wire logic [met_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input wire logic [met_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [met_pkg::M_TDATA_W-1:0]    m_tdata,   // iteration_count, final_magnitude_sq
    input wire logic                             m_tuser    // inside_set
);

    logic [met_pkg::COUNT_BITS-1:0] lim_reg;
    logic [met_pkg::MAGSQ_W-1:0]    bail_reg;
    logic [met_pkg::COUNT_BITS-1:0] out_count;
    logic [met_pkg::MAGSQ_W-1:0]    out_mag;

    assign out_count = m_tdata[met_pkg::COUNT_BITS-1:0];
    assign out_mag   = m_tdata[met_pkg::COUNT_BITS+met_pkg::MAGSQ_W-1:met_pkg::COUNT_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg  <= met_pkg::MAX_ITER_RST;
            bail_reg <= met_pkg::BAILOUT_RST;
        end else if (cfg_wr_en) begin
            if (cfg_addr == met_pkg::CFG_MAX_ITER) begin
                lim_reg <= cfg_wdata[met_pkg::COUNT_BITS-1:0];
            end
            if (cfg_addr == met_pkg::CFG_BAILOUT) begin
                bail_reg <= cfg_wdata[met_pkg::MAGSQ_W-1:0];
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready while a point is in work");

    a_inside_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> out_count == lim_reg)
        else $error("inside point without count at limit");

    a_escape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (out_count < lim_reg)
            && (out_mag > bail_reg || out_mag == met_pkg::MAGSQ_MAX))
        else $error("escaped point inconsistent with limit or bailout");

endmodule

bind mandelbrot_escape_time_top met_checker u_met_checker (.*);
`default_nettype wire

### tb/sv/mandelbrot_escape_time_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_top_tb: self-checking bench for the escape-time block
// Streams complex points into the block under several register settings and
// checks count, inside flag and final |z|^2 of every result against an
// in-bench fixed-point model of the iteration. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_top_tb;
    import met_pkg::*;

    localparam int Q_ONE   = 1 << FRAC_BITS;
    localparam int Q_MAX   = 32'h7FFF_FFFF;
    localparam int Q_MIN   = int'(32'h8000_0000);
    localparam int DRAIN_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam bit [127:0] PRODUCT_CAP = 128'd1 << 61;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  in_set;
        logic [MAGSQ_W-1:0]    mag_sq;
    } escape_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;  // c_real, c_imag
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;         // iteration_count, final_magnitude_sq
    logic                  m_tuser;         // inside_set

    logic [COUNT_BITS-1:0] iter_limit  = MAX_ITER_RST;
    logic [MAGSQ_W-1:0]    bailout_sq  = BAILOUT_RST;
    logic [PER_W-1:0]      snap_period = PERIOD_RST;

    escape_result_t pending_escapes[$];
    int             mismatch_count = 0;
    int             stall_left     = 0;
    bit             idle_on        = 1'b1;

    mandelbrot_escape_time_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // signed product truncated toward zero, magnitude capped
    function automatic longint fx_product(longint a, longint b, int shift);
        bit [127:0] mag_a;
        bit [127:0] mag_b;
        bit [127:0] prod;
        bit         negative;
        negative = (a < 0) != (b < 0);
        mag_a = (a < 0) ? 128'(-a) : 128'(a);
        mag_b = (b < 0) ? 128'(-b) : 128'(b);
        prod = (mag_a * mag_b) >> shift;
        if (prod > PRODUCT_CAP)
            prod = PRODUCT_CAP;
        return negative ? -$signed(prod[63:0]) : $signed(prod[63:0]);
    endfunction

    function automatic escape_result_t predict_escape(bit [31:0] re_bits, bit [31:0] im_bits);
        longint          cx, cy, x, y, px, py, x2, y2, t, q, u;
        longint unsigned count, pc, limit, sum_sq;
        bit              in_set, early;
        escape_result_t  res;
        cx = $signed(re_bits);
        cy = $signed(im_bits);
        x = cx;
        y = cy;
        px = cx;
        py = cy;
        limit = iter_limit;
        count = 1;
        pc = 1;
        in_set = 1'b0;
        early = 1'b0;
        y2 = fx_product(cy, cy, FRAC_BITS);
        x2 = fx_product(cx, cx, FRAC_BITS);
        sum_sq = x2 + y2;
        // main cardioid, then period-2 bulb
        t = cx - longint'(QUARTER);
        q = fx_product(t, t, FRAC_BITS) + y2;
        if (fx_product(q, q + t, FRAC_BITS) <= fx_product(longint'(QUARTER), y2, FRAC_BITS)) begin
            early = 1'b1;
        end else begin
            u = cx + longint'(ONE);
            if (fx_product(u, u, FRAC_BITS) + y2 <= longint'(SIXTEENTH))
                early = 1'b1;
        end
        if (early) begin
            in_set = 1'b1;
            count = limit;
        end else begin
            while (count < limit && sum_sq <= bailout_sq) begin
                y = fx_product(x, y, FRAC_BITS - 1) + cy;
                x = x2 - y2 + cx;
                x2 = fx_product(x, x, FRAC_BITS);
                y2 = fx_product(y, y, FRAC_BITS);
                sum_sq = x2 + y2;
                count++;
                pc++;
                if (pc >= snap_period) begin
                    pc = 0;
                    if (px == x && py == y) begin
                        in_set = 1'b1;
                        break;
                    end
                    px = x;
                    py = y;
                end
            end
            if (count >= limit)
                in_set = 1'b1;
            if (in_set)
                count = limit;
        end
        res.count  = count[COUNT_BITS-1:0];
        res.in_set = in_set;
        res.mag_sq = (sum_sq > MAGSQ_MAX) ? MAGSQ_MAX : sum_sq[MAGSQ_W-1:0];
        return res;
    endfunction

    function automatic bit [63:0] pack_point(int re, int im);
        return {im[31:0], re[31:0]};
    endfunction

    // points on or near cycles, bulb edges and the cardioid cusp
    function automatic bit [63:0] near_seed(int spread);
        int re, im;
        case ($urandom_range(0, 8))
            0:       begin re = -201326592; im = 0;          end
            1:       begin re = 67108864;   im = 0;          end
            2:       begin re = -335544320; im = 0;          end
            3:       begin re = -32910187;  im = 199957572;  end
            4:       begin re = -32910187;  im = -199957572; end
            5:       begin re = -471077389; im = 0;          end
            6:       begin re = -351838334; im = 0;          end
            7:       begin re = -2 * Q_ONE; im = 0;          end
            default: begin re = 0;          im = Q_ONE;      end
        endcase
        re += int'($urandom_range(0, 2 * spread)) - spread;
        im += int'($urandom_range(0, 2 * spread)) - spread;
        return pack_point(re, im);
    endfunction

    function automatic bit [63:0] random_point();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return pack_point(-603979776 + int'($urandom_range(0, 805306368)),
                              -402653184 + int'($urandom_range(0, 805306368)));
        if (pick < 78)
            return near_seed(1 << 20);
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    task automatic send_point(bit [63:0] point);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= point;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_escapes.push_back(predict_escape(point[31:0], point[63:32]));
    endtask

    task automatic wait_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_escapes.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_regs(bit [15:0] lim, bit [33:0] bail, bit [15:0] per);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_MAX_ITER;
        cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge aclk);
        cfg_addr  <= CFG_BAILOUT;
        cfg_wdata <= bail;
        @(posedge aclk);
        cfg_addr  <= CFG_PERIOD;
        cfg_wdata <= CFG_DATA_W'(per);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        iter_limit  = lim;
        bailout_sq  = bail;
        snap_period = per;
    endtask

    task automatic check_escape_result();
        escape_result_t want;
        if (pending_escapes.size() == 0) begin
            $display("%0t unexpected result: count %0d inside %0b mag_sq %0h",
                     $time, m_tdata[15:0], m_tuser, m_tdata[49:16]);
            mismatch_count++;
        end else begin
            want = pending_escapes.pop_front();
            if (m_tdata[15:0] !== want.count) begin
                $display("%0t iteration_count mismatch: expected %0d actual %0d",
                         $time, want.count, m_tdata[15:0]);
                mismatch_count++;
            end
            if (m_tuser !== want.in_set) begin
                $display("%0t inside_set mismatch: expected %0b actual %0b",
                         $time, want.in_set, m_tuser);
                mismatch_count++;
            end
            if (m_tdata[49:16] !== want.mag_sq) begin
                $display("%0t final_magnitude_sq mismatch: expected %0h actual %0h",
                         $time, want.mag_sq, m_tdata[49:16]);
                mismatch_count++;
            end
            if (m_tdata[M_TDATA_W-1:50] !== '0) begin
                $display("%0t tdata padding mismatch: expected 0 actual %0h",
                         $time, m_tdata[M_TDATA_W-1:50]);
                mismatch_count++;
            end
        end
    endtask

    // result side: check every accepted item, stall at random
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_escape_result();
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 2) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    task automatic test_directed_points();
        send_point(pack_point(0, 0));
        send_point(pack_point(Q_ONE / 4, 0));
        send_point(pack_point(-201326592, 0));
        send_point(pack_point(-Q_ONE, 0));
        send_point(pack_point(-335544320, 0));
        send_point(pack_point(-2 * Q_ONE, 0));
        send_point(pack_point(0, Q_ONE));
        send_point(pack_point(2 * Q_ONE, 0));
        send_point(pack_point(Q_ONE, Q_ONE));
        send_point(pack_point(Q_MAX, Q_MAX));
        send_point(pack_point(Q_MIN, Q_MIN));
        send_point(pack_point(Q_MAX, Q_MIN));
        send_point(pack_point(Q_MIN, 0));
        send_point(pack_point(0, Q_MAX));
        send_point(pack_point(-471077389, 0));
        send_point(pack_point(-32910187, 199957572));
        send_point(pack_point(80530637, 0));
        send_point(pack_point(-134217728, 150323855));
        send_point(pack_point(75564581, 142297636));
        send_point(pack_point(-351838334, 0));
        send_point(pack_point(69793793, 0));
        send_point(pack_point(-1, -1));
    endtask

    task automatic test_random_defaults();
        repeat (100) send_point(random_point());
    endtask

    // zero limit, limit of one, and escape on the last allowed step
    task automatic test_iteration_limits();
        for (int lim = 0; lim < 3; lim++) begin
            wait_idle();
            case (lim)
                0:       write_regs(16'd0, {2'($urandom_range(0, 3)), 32'($urandom)}, 16'd0);
                1:       write_regs(16'd1, 34'd0, 16'd1);
                default: write_regs(16'd2, BAILOUT_RST, 16'd1);
            endcase
            send_point(pack_point(0, 0));
            send_point(pack_point(Q_ONE, 0));
            send_point(pack_point(2 * Q_ONE, 0));
            repeat (4) send_point(random_point());
        end
    endtask

    // highest limit and bailout: only points that leave quickly, plus cardioid hits
    task automatic test_wide_escape();
        int far_mag;
        wait_idle();
        write_regs(16'hFFFF, MAGSQ_MAX, 16'hFFFF);
        repeat (30) begin
            far_mag = int'($urandom_range(3 * Q_ONE, Q_MAX));
            if ($urandom_range(0, 1))
                far_mag = -far_mag;
            if ($urandom_range(0, 1))
                send_point(pack_point(far_mag, int'($urandom)));
            else
                send_point(pack_point(int'($urandom), far_mag));
        end
        repeat (5) send_point(pack_point(int'($urandom_range(0, 1 << 26)) - (1 << 25),
                                         int'($urandom_range(0, 1 << 26)) - (1 << 25)));
        send_point(pack_point(Q_MAX, Q_MAX));
        send_point(pack_point(Q_MIN, Q_MIN));
        send_point(pack_point(Q_MIN, Q_MAX));
        send_point(pack_point(3 * Q_ONE, 0));
        send_point(pack_point(-3 * Q_ONE, 0));
    endtask

    task automatic test_periodicity();
        int periods[6] = '{1, 2, 3, 7, 20, 64};
        idle_on = 1'b0;
        foreach (periods[i]) begin
            wait_idle();
            write_regs(16'd150, BAILOUT_RST, 16'(periods[i]));
            for (int n = 0; n < 10; n++)
                send_point(near_seed((n % 2 == 0) ? 0 : (1 << 14)));
            idle_on = (i >= 2);
        end
        idle_on = 1'b1;
    endtask

    task automatic test_random_settings();
        bit [33:0] bail;
        repeat (8) begin
            case ($urandom_range(0, 3))
                0:       bail = BAILOUT_RST;
                1:       bail = 34'd1 << (FRAC_BITS + 4);
                2:       bail = {2'($urandom_range(0, 3)), 32'($urandom)};
                default: bail = 34'($urandom_range(0, 1 << 30));
            endcase
            wait_idle();
            write_regs(16'($urandom_range(2, 64)), bail, 16'($urandom_range(0, 40)));
            idle_on = ($urandom_range(0, 3) != 0);
            repeat (75) send_point(random_point());
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_points();
        test_random_defaults();
        test_iteration_limits();
        test_wide_escape();
        test_periodicity();
        test_random_settings();
        wait_idle();
        repeat (200) @(posedge aclk);
        if (pending_escapes.size() != 0)
            $display("%0t %0d results never arrived", $time, pending_escapes.size());
        if (mismatch_count == 0 && pending_escapes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
hdl/met_pkg.sv
hdl/met_mul.sv
hdl/mandelbrot_escape_time_top.sv
hdl/met_checker.sv
tb/sv/mandelbrot_escape_time_top_tb.sv
